// ===== rtl/nps_pkg.sv =====
// Package for the nearest point search block: shared constants, opcodes,
// control state type and the scan status bundle.
// No dependencies.

package nps_pkg;

    // default geometry of the point store
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_COORD_BITS  = 16;

    // fixed field widths of the request, result and configuration channels
    localparam int POS_W   = 16;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int DIST_W  = 17;

    // largest distance the result field can carry
    localparam logic [DIST_W-1:0] DIST_MAX = 17'd131071;

    // request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // top level control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_HOLD
    } nps_state_t;

    // status from the scan unit to the top level
    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

endpackage

// ===== rtl/nps_sqrt_cell.sv =====
// One cell of the integer square root chain: consumes two radicand bits,
// produces one root bit and hands the partial state to the next cell.
// Depends on nps_pkg for the default root width.

module nps_sqrt_cell #(
    parameter int ROOT_W = nps_pkg::DEF_COORD_BITS + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                v_in,
    input  logic [2*ROOT_W-1:0] rad_in,
    input  logic [ROOT_W:0]     rem_in,
    input  logic [ROOT_W-1:0]   root_in,
    output logic                v_out,
    output logic [2*ROOT_W-1:0] rad_out,
    output logic [ROOT_W:0]     rem_out,
    output logic [ROOT_W-1:0]   root_out
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int CUR_W = REM_W + 2;

    logic                v_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [REM_W-1:0]    rem_next;
    logic [ROOT_W-1:0]   root_next;
    logic [CUR_W-1:0]    cur;
    logic [CUR_W-1:0]    trial;

    // bring down the next two radicand bits and try the next root bit
    assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = CUR_W'({root_in, 2'b01});

    always_comb
    begin
        if (cur >= trial)
        begin
            rem_next  = REM_W'(cur - trial);
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = REM_W'(cur);
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    // valid tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= v_in;
    end

    // partial state handed on
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_in << 2;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign v_out    = v_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== rtl/nps_scan.sv =====
// Scan unit: point store, per-entry squared distance pipeline and running
// minimum with strict compare.
// Depends on nps_pkg.

module nps_scan #(
    parameter int TABLE_DEPTH = nps_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = nps_pkg::DEF_COORD_BITS,
    localparam int ADDR_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int SUM_W      = 2 * COORD_BITS + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [COORD_BITS-1:0]         qx,
    input  logic [COORD_BITS-1:0]         qy,
    input  logic [nps_pkg::COUNT_W-1:0]   entry_count,
    input  logic                          wr_en,
    input  logic [nps_pkg::INDEX_W-1:0]   wr_index,
    input  logic [COORD_BITS-1:0]         wr_x,
    input  logic [COORD_BITS-1:0]         wr_y,
    output nps_pkg::scan_status_t         status,
    output logic [ADDR_W-1:0]             best_idx,
    output logic [SUM_W-1:0]              best_sq
);

    localparam int CB     = COORD_BITS;
    localparam int SQ_W   = 2 * CB;
    localparam int CNT_W  = (ADDR_W + 1 > nps_pkg::COUNT_W) ? ADDR_W + 1 : nps_pkg::COUNT_W;

    logic [2*CB-1:0]  point_table_reg [0:TABLE_DEPTH-1];

    logic             running_reg;
    logic             issue_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] limit_next;
    logic [CB-1:0]    qx_reg;
    logic [CB-1:0]    qy_reg;

    logic              rd_valid_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [2*CB-1:0]   rd_data_reg;

    logic              diff_valid_reg;
    logic [ADDR_W-1:0] diff_idx_reg;
    logic [CB-1:0]     abs_x_reg;
    logic [CB-1:0]     abs_y_reg;
    logic [CB-1:0]     abs_x_next;
    logic [CB-1:0]     abs_y_next;

    logic              sq_valid_reg;
    logic [ADDR_W-1:0] sq_idx_reg;
    logic [SQ_W-1:0]   sq_x_reg;
    logic [SQ_W-1:0]   sq_y_reg;
    logic [SQ_W-1:0]   sq_x_next;
    logic [SQ_W-1:0]   sq_y_next;

    logic              sum_valid_reg;
    logic [ADDR_W-1:0] sum_idx_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic              best_found_reg;
    logic [ADDR_W-1:0] best_idx_reg;
    logic [SUM_W-1:0]  best_sq_reg;
    logic              done_reg;
    logic              drained;
    logic              wr_in_range;
    logic              take_best;

    logic signed [CB:0] dx;
    logic signed [CB:0] dy;

    // rows beyond the store are dropped
    assign wr_in_range = int'(wr_index) < TABLE_DEPTH;

    // point store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
            point_table_reg[ADDR_W'(wr_index)] <= {wr_x, wr_y};
        if (issue_reg)
            rd_data_reg <= point_table_reg[cnt_reg[ADDR_W-1:0]];
    end

    // scan length saturates at the store depth
    assign limit_next = (CNT_W'(entry_count) > CNT_W'(TABLE_DEPTH)) ?
                        CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count);

    assign drained = !issue_reg && !rd_valid_reg && !diff_valid_reg &&
                     !sq_valid_reg && !sum_valid_reg;

    // scan sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            issue_reg   <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            limit_reg   <= '0;
        end
        else
        begin
            done_reg <= running_reg && drained;
            if (start)
            begin
                running_reg <= 1'b1;
                issue_reg   <= (limit_next != '0);
                cnt_reg     <= '0;
                limit_reg   <= limit_next;
            end
            else
            begin
                if (running_reg && drained)
                    running_reg <= 1'b0;
                if (issue_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 == limit_reg)
                        issue_reg <= 1'b0;
                end
            end
        end
    end

    // query position
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qx_reg <= qx;
            qy_reg <= qy;
        end
    end

    // absolute coordinate differences
    assign dx = $signed({qx_reg[CB-1], qx_reg}) -
                $signed({rd_data_reg[2*CB-1], rd_data_reg[2*CB-1:CB]});
    assign dy = $signed({qy_reg[CB-1], qy_reg}) -
                $signed({rd_data_reg[CB-1], rd_data_reg[CB-1:0]});
    assign abs_x_next = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    assign abs_y_next = dy[CB] ? CB'(-dy) : dy[CB-1:0];

    // squares
    assign sq_x_next = SQ_W'(abs_x_reg) * SQ_W'(abs_x_reg);
    assign sq_y_next = SQ_W'(abs_y_reg) * SQ_W'(abs_y_reg);

    // valid tags through the distance pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            diff_valid_reg <= 1'b0;
            sq_valid_reg   <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= issue_reg;
            diff_valid_reg <= rd_valid_reg;
            sq_valid_reg   <= diff_valid_reg;
            sum_valid_reg  <= sq_valid_reg;
        end
    end

    // distance pipeline payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= cnt_reg[ADDR_W-1:0];
        diff_idx_reg <= rd_idx_reg;
        abs_x_reg    <= abs_x_next;
        abs_y_reg    <= abs_y_next;
        sq_idx_reg   <= diff_idx_reg;
        sq_x_reg     <= sq_x_next;
        sq_y_reg     <= sq_y_next;
        sum_idx_reg  <= sq_idx_reg;
        sum_reg      <= SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg);
    end

    // running minimum, earliest row wins a tie
    assign take_best = sum_valid_reg && (!best_found_reg || sum_reg < best_sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_found_reg <= 1'b0;
        else if (start)
            best_found_reg <= 1'b0;
        else if (take_best)
            best_found_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            best_idx_reg <= '0;
            best_sq_reg  <= '0;
        end
        else if (take_best)
        begin
            best_idx_reg <= sum_idx_reg;
            best_sq_reg  <= sum_reg;
        end
    end

    assign status.done  = done_reg;
    assign status.found = best_found_reg;
    assign best_idx     = best_idx_reg;
    assign best_sq      = best_sq_reg;

endmodule

// ===== rtl/nearest_point_search.sv =====
// Nearest point search top level: request/result handshakes, entry_count
// register, control FSM and the square root cell chain.
// Depends on nps_pkg, nps_scan and nps_sqrt_cell.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+--------------------------------
//   in       | in        | in_valid / in_ready    | opcode, entry_index, pos_x, pos_y
//   out      | out       | out_valid / out_ready  | found, nearest_index,
//            |           |                        | nearest_distance
//   cfg      | in        | cfg_valid / cfg_ready  | cfg_data (entry_count)
//
// A query scans entry_count rows (capped at TABLE_DEPTH): one store row is read
// per cycle, then come the difference, square, sum and minimum registers and a
// chain of COORD_BITS+1 root cells. An empty scan skips the distance pipeline.
// Reset clears control and entry_count; the point store is not cleared.
// A finished result waits in the output register; a new request is taken
// meanwhile, and a later result waits in the hold state until out is free.

module nearest_point_search #(
    parameter int TABLE_DEPTH = nps_pkg::DEF_TABLE_DEPTH,
    parameter int COORD_BITS  = nps_pkg::DEF_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [nps_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [nps_pkg::POS_W-1:0]   pos_x,
    input  logic signed [nps_pkg::POS_W-1:0]   pos_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [nps_pkg::INDEX_W-1:0]        nearest_index,
    output logic [nps_pkg::DIST_W-1:0]         nearest_distance,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nps_pkg::COUNT_W-1:0]        cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SUM_W  = 2 * COORD_BITS + 1;
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int DIST_W = nps_pkg::DIST_W;
    localparam int EXT_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

    nps_pkg::nps_state_t state_reg;
    nps_pkg::nps_state_t state_next;

    logic [nps_pkg::COUNT_W-1:0] entry_count_reg;

    logic                  in_fire;
    logic                  query_start;
    logic                  write_en;
    logic                  out_load;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;

    nps_pkg::scan_status_t scan_status;
    logic [ADDR_W-1:0]     scan_best_idx;
    logic [SUM_W-1:0]      scan_best_sq;

    logic                  chain_valid [0:ROOT_W];
    logic [RAD_W-1:0]      chain_rad   [0:ROOT_W];
    logic [ROOT_W:0]       chain_rem   [0:ROOT_W];
    logic [ROOT_W-1:0]     chain_root  [0:ROOT_W];

    logic [EXT_W-1:0]      root_ext;
    logic [DIST_W-1:0]     dist_sat;

    logic                        res_found_reg;
    logic [nps_pkg::INDEX_W-1:0] res_idx_reg;
    logic [DIST_W-1:0]           res_dist_reg;

    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [nps_pkg::INDEX_W-1:0] out_idx_reg;
    logic [DIST_W-1:0]           out_dist_reg;

    // configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_count_reg <= '0;
        else if (cfg_valid && cfg_ready)
            entry_count_reg <= cfg_data;
    end

    // coordinates keep their low COORD_BITS bits
    assign px = COORD_BITS'($unsigned(pos_x));
    assign py = COORD_BITS'($unsigned(pos_y));

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nps_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nps_pkg::ST_IDLE:
            begin
                if (in_valid && opcode == nps_pkg::OP_QUERY)
                    state_next = nps_pkg::ST_BUSY;
            end
            nps_pkg::ST_BUSY:
            begin
                if (chain_valid[ROOT_W])
                    state_next = nps_pkg::ST_HOLD;
            end
            nps_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = nps_pkg::ST_IDLE;
            end
            default:
                state_next = nps_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            nps_pkg::ST_IDLE:
                in_ready = 1'b1;
            nps_pkg::ST_BUSY:
                in_ready = 1'b0;
            nps_pkg::ST_HOLD:
                out_load = !out_valid_reg || out_ready;
            default:
            begin
                in_ready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign in_fire     = in_valid && in_ready;
    assign query_start = in_fire && opcode == nps_pkg::OP_QUERY;
    assign write_en    = in_fire && opcode == nps_pkg::OP_WRITE;

    // store and distance scan
    nps_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (query_start),
        .qx          (px),
        .qy          (py),
        .entry_count (entry_count_reg),
        .wr_en       (write_en),
        .wr_index    (entry_index),
        .wr_x        (px),
        .wr_y        (py),
        .status      (scan_status),
        .best_idx    (scan_best_idx),
        .best_sq     (scan_best_sq)
    );

    // square root chain, fed by the minimum at the end of a scan
    assign chain_valid[0] = scan_status.done;
    assign chain_rad[0]   = RAD_W'(scan_best_sq);
    assign chain_rem[0]   = '0;
    assign chain_root[0]  = '0;

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_root
        nps_sqrt_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .v_in     (chain_valid[g]),
            .rad_in   (chain_rad[g]),
            .rem_in   (chain_rem[g]),
            .root_in  (chain_root[g]),
            .v_out    (chain_valid[g+1]),
            .rad_out  (chain_rad[g+1]),
            .rem_out  (chain_rem[g+1]),
            .root_out (chain_root[g+1])
        );
    end

    // root saturates to the result field
    assign root_ext = EXT_W'(chain_root[ROOT_W]);
    assign dist_sat = (root_ext > EXT_W'(nps_pkg::DIST_MAX)) ?
                      nps_pkg::DIST_MAX : DIST_W'(root_ext);

    // result capture
    always_ff @(posedge clk)
    begin
        if (scan_status.done)
        begin
            res_found_reg <= scan_status.found;
            res_idx_reg   <= nps_pkg::INDEX_W'(scan_best_idx);
        end
        if (chain_valid[ROOT_W])
            res_dist_reg <= dist_sat;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_found_reg <= res_found_reg;
            out_idx_reg   <= res_idx_reg;
            out_dist_reg  <= res_dist_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign found            = out_found_reg;
    assign nearest_index    = out_idx_reg;
    assign nearest_distance = out_dist_reg;

    // a query request always starts a scan
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        query_start |=> state_reg == nps_pkg::ST_BUSY)
        else $error("query request did not start a scan");

    // scan completion only while a query is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        scan_status.done |-> state_reg == nps_pkg::ST_BUSY)
        else $error("scan finished outside a query");

    // root leaves the chain only while a query is in flight
    a_root_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[ROOT_W] |-> state_reg == nps_pkg::ST_BUSY)
        else $error("root result outside a query");

    // final root: radicand fully consumed and remainder within twice the root
    a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[ROOT_W] |-> (chain_rad[ROOT_W] == '0) &&
            ((ROOT_W+2)'(chain_rem[ROOT_W]) <= (ROOT_W+2)'({chain_root[ROOT_W], 1'b0})))
        else $error("square root chain out of bounds");

    // an empty scan reports zero index and distance
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (nearest_index == '0) && (nearest_distance == '0))
        else $error("empty scan result not zero");

endmodule
